// ----- rtl/core/lebuf_pkg.sv -----
// Shared types and codes for the line edit buffer.
`timescale 1ns / 1ps

package lebuf_pkg;

   typedef enum logic [2:0] {
      CMD_START     = 3'd0,
      CMD_CHAR      = 3'd1,
      CMD_BACKSPACE = 3'd2,
      CMD_DELETE    = 3'd3,
      CMD_LEFT      = 3'd4,
      CMD_RIGHT     = 3'd5,
      CMD_ENTER     = 3'd6,
      CMD_ESCAPE    = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_EMPTY  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_CHAR,
      ST_SHD_RD,
      ST_SHD_WR,
      ST_POST_RD,
      ST_POST_WR,
      ST_STATUS
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       pressed;
      logic [7:0] char_code;
   } req_word_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      logic [5:0] cursor_pos;
      logic [5:0] line_length;
      logic       editing;
      logic       last;
   } rsp_word_type;

endpackage

// ----- rtl/core/line_edit_buffer_core.sv -----
// Line edit buffer: key-driven single-line editor around one byte memory.
`timescale 1ns / 1ps

// Takes one key word at a time and answers with one status word, or, for enter
// while editing, one word per held byte (a single empty-message word when the
// line is empty), the final word flagged by last. The line lives in a
// BUF_SIZE x 8 memory with one write port and one registered read port; every
// move of a byte is a read step followed by a write step. An insert moves each
// byte right of the cursor up one place before writing the new byte; backspace
// or delete move the bytes after the removed one down; enter reads each posted
// byte before loading its word. req_stall stays high from acceptance until the
// final result word has been loaded into the output register, so the next key
// can be taken while that word still waits on rsp_stall. The line holds at most
// BUF_SIZE-1 bytes; cursor_pos and line_length carry the low six bits of the
// counts. No memory clearing pass follows reset: only bytes below the length
// are read.

module line_edit_buffer_core #(
   parameter int BUF_SIZE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lebuf_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lebuf_pkg::rsp_word_type rsp_word
);

   import lebuf_pkg::*;

   localparam int PTR_W = $clog2(BUF_SIZE);
   localparam logic [PTR_W-1:0] LEN_MAX = PTR_W'(BUF_SIZE - 1);
   localparam logic [PTR_W-1:0] ONE     = PTR_W'(1);

   // control state
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] cursor_ff, cursor_in;
   logic [PTR_W-1:0] len_ff, len_in;
   logic             active_ff, active_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // per-key working registers (no reset needed)
   logic [PTR_W-1:0] idx_ff, idx_in;     // walking memory index
   logic [7:0]       ch_ff, ch_in;       // byte to insert
   logic             bs_ff, bs_in;       // shift-down is a backspace
   logic             empty_ff, empty_in; // status word reports an empty post
   rsp_word_type     rsp_word_ff, rsp_word_in;

   // line memory
   logic [7:0]       line_mem [BUF_SIZE];
   logic [7:0]       rd_data_ff;
   logic             rd_en, wr_en;
   logic [PTR_W-1:0] rd_addr, wr_addr;
   logic [7:0]       wr_data;

   logic             slot_free;
   logic [PTR_W-1:0] cur_inc, cur_dec, idx_inc, idx_dec;
   logic [PTR_W+5:0] cur_ext, len_ext;
   logic [5:0]       cur6, len6;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cur_inc   = cursor_ff + ONE;
   assign cur_dec   = cursor_ff - ONE;
   assign idx_inc   = idx_ff + ONE;
   assign idx_dec   = idx_ff - ONE;

   // counts go out as their low six bits, zero-extended for a small buffer
   assign cur_ext = {6'b0, cursor_ff};
   assign len_ext = {6'b0, len_ff};
   assign cur6    = cur_ext[5:0];
   assign len6    = len_ext[5:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         len_ff       <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         len_ff       <= len_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      ch_ff       <= ch_in;
      bs_ff       <= bs_in;
      empty_ff    <= empty_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      len_in       = len_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      ch_in        = ch_ff;
      bs_in        = bs_ff;
      empty_in     = empty_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STATUS;
               empty_in = 1'b0;
               if (req_word.pressed && req_word.cmd == CMD_START) begin
                  cursor_in = '0;
                  len_in    = '0;
                  active_in = 1'b1;
               end else if (req_word.pressed && active_ff) begin
                  unique case (req_word.cmd)
                     CMD_START: begin
                        // handled above
                     end
                     CMD_CHAR: begin
                        if (req_word.char_code != 8'd0 && len_ff < LEN_MAX &&
                            cursor_ff <= len_ff) begin
                           ch_in  = req_word.char_code;
                           idx_in = len_ff;
                           state_in = (len_ff > cursor_ff) ? ST_INS_RD : ST_INS_CHAR;
                        end
                     end
                     CMD_BACKSPACE: begin
                        if (cursor_ff != '0 && cursor_ff <= len_ff) begin
                           bs_in = 1'b1;
                           if (cursor_ff < len_ff) begin
                              idx_in   = cursor_ff;
                              state_in = ST_SHD_RD;
                           end else begin
                              cursor_in = cur_dec;
                              len_in    = len_ff - ONE;
                           end
                        end
                     end
                     CMD_DELETE: begin
                        if (cursor_ff < len_ff) begin
                           bs_in = 1'b0;
                           if (cur_inc < len_ff) begin
                              idx_in   = cur_inc;
                              state_in = ST_SHD_RD;
                           end else begin
                              len_in = len_ff - ONE;
                           end
                        end
                     end
                     CMD_LEFT: begin
                        if (cursor_ff != '0) begin
                           cursor_in = cur_dec;
                        end
                     end
                     CMD_RIGHT: begin
                        if (cursor_ff < len_ff) begin
                           cursor_in = cur_inc;
                        end
                     end
                     CMD_ENTER: begin
                        active_in = 1'b0;
                        if (len_ff == '0) begin
                           empty_in = 1'b1;
                        end else begin
                           idx_in   = '0;
                           state_in = ST_POST_RD;
                        end
                     end
                     CMD_ESCAPE: begin
                        active_in = 1'b0;
                     end
                  endcase
               end
            end
         end

         // open a gap: move byte idx-1 up to idx, walking down to the cursor
         ST_INS_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_dec;
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = idx_dec;
            state_in = (idx_dec == cursor_ff) ? ST_INS_CHAR : ST_INS_RD;
         end
         ST_INS_CHAR: begin
            wr_en     = 1'b1;
            wr_addr   = cursor_ff;
            wr_data   = ch_ff;
            cursor_in = cur_inc;
            len_in    = len_ff + ONE;
            state_in  = ST_STATUS;
         end

         // close a gap: move byte idx down to idx-1 up to the end of line
         ST_SHD_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_SHD_WR;
         end
         ST_SHD_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_dec;
            wr_data = rd_data_ff;
            idx_in  = idx_inc;
            if (idx_inc == len_ff) begin
               len_in = len_ff - ONE;
               if (bs_ff) begin
                  cursor_in = cur_dec;
               end
               state_in = ST_STATUS;
            end else begin
               state_in = ST_SHD_RD;
            end
         end

         // post the line, one word per byte
         ST_POST_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = ST_POST_WR;
         end
         ST_POST_WR: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.kind        = KIND_BYTE;
               rsp_word_in.char_out    = rd_data_ff;
               rsp_word_in.cursor_pos  = cur6;
               rsp_word_in.line_length = len6;
               rsp_word_in.editing     = active_ff;
               rsp_word_in.last        = (idx_inc == len_ff);
               idx_in                  = idx_inc;
               state_in = (idx_inc == len_ff) ? ST_IDLE : ST_POST_RD;
            end
         end

         ST_STATUS: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.kind        = empty_ff ? KIND_EMPTY : KIND_STATUS;
               rsp_word_in.char_out    = 8'd0;
               rsp_word_in.cursor_pos  = cur6;
               rsp_word_in.line_length = len6;
               rsp_word_in.editing     = active_ff;
               rsp_word_in.last        = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // cursor never runs past the end of the line
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= len_ff)
      else $error("cursor beyond line length");

   // the line never grows past its capacity
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_MAX)
      else $error("line length beyond capacity");

   // a pressed start always leaves an active, empty line
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_word.pressed && req_word.cmd == CMD_START
      |=> active_ff && len_ff == '0 && cursor_ff == '0)
      else $error("start did not clear the line");

   // posting only walks bytes that are held
   a_post_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST_RD || state_ff == ST_POST_WR) |-> idx_ff < len_ff)
      else $error("post index beyond line length");

   // a byte word is only ever produced while the editor is off
   a_post_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.kind == KIND_BYTE |-> !rsp_word_ff.editing)
      else $error("message byte posted while editing");

endmodule

// ----- sim/tb_line_edit_buffer_core.sv -----
// Self-checking testbench for the line edit buffer core.
`timescale 1ns / 1ps

module tb_line_edit_buffer_core;
   import lebuf_pkg::*;

   localparam int LINE_BYTES   = 64;
   localparam int SCRIPT_ROWS  = 25;
   localparam int RANDOM_KEYS  = 400;
   localparam int HOLD_AFTER   = 150;   // result words taken before the long hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;   // worst insert shift plus a stalled result
   localparam int MAX_REPORTS  = 10;

   // one directed step: key word, and the answer where it is obvious enough to type in
   typedef struct packed {
      req_word_type key;
      logic         typed;
      rsp_word_type want;
   } script_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // editor image kept alongside the block
   logic [7:0]   line_buf [LINE_BYTES];
   logic [5:0]   cur_pos  = '0;
   logic [5:0]   line_len = '0;
   logic         editing  = 1'b0;

   rsp_word_type fresh_words[$];   // answers to the key just taken
   rsp_word_type due_words[$];     // answers still owed by the block
   int unsigned  keys_sent = 0;
   int unsigned  errors    = 0;

   // Directed part. Typed answers cover the idle editor after reset, released keys,
   // the empty post and the no-change keys on an empty line; the rest goes through the image.
   script_row_type script [SCRIPT_ROWS] = '{
      '{'{CMD_LEFT,      1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{'{CMD_CHAR,      1'b1, 8'hFF}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{'{CMD_ENTER,     1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{'{CMD_START,     1'b0, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{'{CMD_START,     1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_ENTER,     1'b1, 8'h00}, 1'b1, '{KIND_EMPTY,  8'h00, 6'd0, 6'd0, 1'b0, 1'b1}},
      '{'{CMD_START,     1'b1, 8'hA5}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_CHAR,      1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_BACKSPACE, 1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_DELETE,    1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_LEFT,      1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_RIGHT,     1'b1, 8'h00}, 1'b1, '{KIND_STATUS, 8'h00, 6'd0, 6'd0, 1'b1, 1'b1}},
      '{'{CMD_CHAR,      1'b1, 8'hFF}, 1'b1, '{KIND_STATUS, 8'h00, 6'd1, 6'd1, 1'b1, 1'b1}},
      '{'{CMD_CHAR,      1'b0, 8'h7E}, 1'b1, '{KIND_STATUS, 8'h00, 6'd1, 6'd1, 1'b1, 1'b1}},
      '{'{CMD_CHAR,      1'b1, 8'h01}, 1'b1, '{KIND_STATUS, 8'h00, 6'd2, 6'd2, 1'b1, 1'b1}},
      '{'{CMD_LEFT,      1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_CHAR,      1'b1, 8'h80}, 1'b0, '0},
      '{'{CMD_LEFT,      1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_BACKSPACE, 1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_DELETE,    1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_RIGHT,     1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_ENTER,     1'b1, 8'h00}, 1'b0, '0},
      '{'{CMD_START,     1'b1, 8'h3C}, 1'b0, '0},
      '{'{CMD_CHAR,      1'b1, 8'h42}, 1'b0, '0},
      '{'{CMD_ESCAPE,    1'b1, 8'h00}, 1'b0, '0}
   };

   line_edit_buffer_core #(
      .BUF_SIZE (LINE_BYTES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #5 clock = ~clock;

   // result word carrying the image's current cursor, length and mode
   function automatic rsp_word_type editor_word(kind_type kind, logic [7:0] ch, logic fin);
      rsp_word_type w;
      w.kind        = kind;
      w.char_out    = ch;
      w.cursor_pos  = cur_pos;
      w.line_length = line_len;
      w.editing     = editing;
      w.last        = fin;
      return w;
   endfunction

   // Applies one key to the editor image and leaves its answers in fresh_words.
   function automatic void apply_key(req_word_type key);
      int i;
      fresh_words.delete();
      if (key.pressed && key.cmd == CMD_START) begin
         cur_pos  = '0;
         line_len = '0;
         editing  = 1'b1;
      end else if (key.pressed && editing) begin
         case (key.cmd)
            CMD_CHAR: begin
               // a full line (one short of the store) drops the byte
               if (key.char_code != 8'h00 && line_len < LINE_BYTES - 1) begin
                  for (i = line_len; i > cur_pos; i--) line_buf[i] = line_buf[i - 1];
                  line_buf[cur_pos] = key.char_code;
                  cur_pos++;
                  line_len++;
               end
            end
            CMD_BACKSPACE: begin
               if (cur_pos > 0) begin
                  for (i = cur_pos; i < line_len; i++) line_buf[i - 1] = line_buf[i];
                  cur_pos--;
                  line_len--;
               end
            end
            CMD_DELETE: begin
               if (cur_pos < line_len) begin
                  for (i = cur_pos; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
                  line_len--;
               end
            end
            CMD_LEFT: begin
               if (cur_pos > 0) cur_pos--;
            end
            CMD_RIGHT: begin
               if (cur_pos < line_len) cur_pos++;
            end
            CMD_ENTER: begin
               // post the line; bytes, cursor and length stay until the next start
               editing = 1'b0;
               if (line_len == 0) begin
                  fresh_words = {fresh_words, editor_word(KIND_EMPTY, 8'h00, 1'b1)};
               end else begin
                  for (i = 0; i < line_len; i++)
                     fresh_words = {fresh_words, editor_word(KIND_BYTE, line_buf[i],
                                                             i + 1 == line_len)};
               end
               return;
            end
            default: begin
               editing = 1'b0;   // escape drops the line but keeps its contents
            end
         endcase
      end
      fresh_words = {fresh_words, editor_word(KIND_STATUS, 8'h00, 1'b1)};
   endfunction

   // Offers one key word, waits for it to be taken, then books its answers.
   // Every fourth run of 32 keys goes without gaps.
   task automatic send_key(req_word_type key, logic typed, rsp_word_type want);
      int unsigned gap;
      gap = (((keys_sent / 32) % 4) == 3) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= key;
      do @(posedge clock); while (req_stall);
      apply_key(key);
      if (typed) begin
         due_words = {due_words, want};
      end else begin
         due_words = {due_words, fresh_words};
      end
      keys_sent++;
   endtask

   // editing key for a session: inserts most often, with the odd dud
   function automatic req_word_type edit_key(logic filling);
      req_word_type key;
      int unsigned  pick;
      key.pressed   = 1'b1;
      key.char_code = 8'($urandom_range(1, 255));
      pick = $urandom_range(0, 99);
      if (filling) begin
         key.cmd = (pick < 85) ? CMD_CHAR : ((pick < 93) ? CMD_LEFT : CMD_RIGHT);
      end else if (pick < 45) begin
         key.cmd = CMD_CHAR;
         if ($urandom_range(0, 19) == 0) key.char_code = 8'h00;
      end else if (pick < 57) begin
         key.cmd = CMD_BACKSPACE;
      end else if (pick < 67) begin
         key.cmd = CMD_DELETE;
      end else if (pick < 79) begin
         key.cmd = CMD_LEFT;
      end else if (pick < 91) begin
         key.cmd = CMD_RIGHT;
      end else if (pick < 96) begin
         // released key of any kind
         key.cmd     = cmd_type'($urandom_range(0, 7));
         key.pressed = 1'b0;
      end else begin
         key.cmd = cmd_type'($urandom_range(0, 7));
      end
      return key;
   endfunction

   // Receiver: a fresh stall count per word, gap-free stretches, and one long
   // hold-off while the sender keeps offering so the block backs up.
   initial begin : rsp_side
      int unsigned hold_for;
      int unsigned taken;
      logic        held;
      taken = 0;
      held  = 1'b0;
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            hold_for = HOLD_CYCLES;
            held     = 1'b1;
         end else if (((taken / 50) % 3) == 1) begin
            hold_for = 0;
         end else begin
            hold_for = $urandom_range(0, 19);
         end
         if (hold_for > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_for) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   // Scoreboard: each word taken is checked against the oldest one owed.
   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_words.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("%0t: unexpected word kind=%0d char=%02h cur=%0d len=%0d ed=%0b last=%0b",
                        $realtime, rsp_word.kind, rsp_word.char_out, rsp_word.cursor_pos,
                        rsp_word.line_length, rsp_word.editing, rsp_word.last);
            errors++;
         end else begin
            want = due_words.pop_front();
            if (rsp_word.kind !== want.kind || rsp_word.char_out !== want.char_out ||
                rsp_word.cursor_pos !== want.cursor_pos ||
                rsp_word.line_length !== want.line_length ||
                rsp_word.editing !== want.editing || rsp_word.last !== want.last) begin
               if (errors < MAX_REPORTS) begin
                  $display("%0t: mismatch, want kind=%0d char=%02h cur=%0d len=%0d ed=%0b last=%0b",
                           $realtime, want.kind, want.char_out, want.cursor_pos,
                           want.line_length, want.editing, want.last);
                  $display("%0t:            got kind=%0d char=%02h cur=%0d len=%0d ed=%0b last=%0b",
                           $realtime, rsp_word.kind, rsp_word.char_out, rsp_word.cursor_pos,
                           rsp_word.line_length, rsp_word.editing, rsp_word.last);
               end
               errors++;
            end
         end
      end
   end

   // Main sequence: reset, directed script, then random editing sessions mixed with noise keys.
   initial begin : key_side
      req_word_type key;
      int unsigned  session_keys;
      int unsigned  pick;
      logic         filling;
      logic         first_session;
      first_session = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++)
         send_key(script[r].key, script[r].typed, script[r].want);

      while (keys_sent < SCRIPT_ROWS + RANDOM_KEYS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // noise: any field, any value
            key.cmd       = cmd_type'($urandom_range(0, 7));
            key.pressed   = 1'($urandom_range(0, 1));
            key.char_code = 8'($urandom_range(0, 255));
            send_key(key, 1'b0, '0);
         end else begin
            // a session: start, edits, then mostly enter or escape; some run on
            // into the next start, which restarts an active line
            filling       = first_session || ($urandom_range(0, 9) == 0);
            first_session = 1'b0;
            session_keys  = filling ? 80 : $urandom_range(1, 20);
            key.cmd       = CMD_START;
            key.pressed   = 1'b1;
            key.char_code = 8'($urandom_range(0, 255));
            send_key(key, 1'b0, '0);
            repeat (session_keys) send_key(edit_key(filling), 1'b0, '0);
            pick = $urandom_range(0, 99);
            if (pick < 90) begin
               key.cmd       = (pick < 65) ? CMD_ENTER : CMD_ESCAPE;
               key.char_code = 8'($urandom_range(0, 255));
               send_key(key, 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin : watchdog
      #50_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
